[rtl/core/rmp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package rmp_pkg;

  // map geometry
  localparam int MAP_ROWS   = 32;
  localparam int MAP_COLS   = 32;
  localparam int CHANNELS   = 16;
  localparam int MAX_POOLED = 8;

  localparam int ROW_W  = $clog2(MAP_ROWS);
  localparam int COL_W  = $clog2(MAP_COLS);
  localparam int CH_W   = $clog2(CHANNELS);
  localparam int ADDR_W = CH_W + ROW_W + COL_W;
  localparam int DEPTH  = CHANNELS * MAP_ROWS * MAP_COLS;
  localparam int DIV_W  = 16;

  // request kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_POOL = 1'b1;

  // register indexes
  localparam logic [2:0] CFG_MAP_HEIGHT    = 3'd0;
  localparam logic [2:0] CFG_MAP_WIDTH     = 3'd1;
  localparam logic [2:0] CFG_POOLED_HEIGHT = 3'd2;
  localparam logic [2:0] CFG_POOLED_WIDTH  = 3'd3;
  localparam logic [2:0] CFG_SPATIAL_SCALE = 3'd4;

  typedef struct packed {
    logic               req_type;
    logic [13:0]        load_address;
    logic signed [15:0] load_value;
    logic [15:0]        roi_x1;
    logic [15:0]        roi_y1;
    logic [15:0]        roi_x2;
    logic [15:0]        roi_y2;
    logic [3:0]         channel;
  } rmp_in_t;

  typedef struct packed {
    logic signed [15:0] pooled_value;
    logic [5:0]         bin_index;
    logic               last;
  } rmp_out_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [15:0]       wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [3:0]       den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

[rtl/core/roi_max_pooling.sv]
// roi max pooling over a 16-channel 32x32 q8.8 feature map store
// input channel: valid/ready requests, req_type selects a load or a pool.
// a load writes one store entry and is taken with no result.
// a pool request scales its q12.4 corners by spatial_scale, splits the roi
// into pooled_height x pooled_width bins and returns one result per bin in
// row-major order, last set on the final bin.
// output channel: valid/ready, one result register; the sequencer holds the
// current result and waits while the receiver stalls, then moves on.
// per pool request: corner scaling through one multiplier shared by the four
// corners, then roi sizing, then per bin 2 divisions on the serial divider
// (4 on the first bin of each bin row) and one store read per cell of the bin;
// cell reads go through the single read port of the store.
// a new request is accepted only once all results of a pool are taken.
// configuration writes are taken at any time and should be made while idle.
// reset returns the registers to 32, 32, 7, 7, 4096 and the sequencer to idle;
// store contents are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module roi_max_pooling (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [2:0]       cfg_index_i,
  input  wire logic [15:0]      cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire rmp_pkg::rmp_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output rmp_pkg::rmp_out_t     out_data_o
);
  import rmp_pkg::*;

  mem_req_t    mem_req;
  logic [15:0] mem_rdata;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  // feature map store
  rmp_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // bin bound divider
  rmp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // sequencer
  rmp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .mem_o       (mem_req),
    .mem_rdata_i (mem_rdata),
    .div_o       (div_req),
    .div_i       (div_rsp)
  );

endmodule
`default_nettype wire

[rtl/core/rmp_store.sv]
`timescale 1ns / 1ps
`default_nettype none
module rmp_store (
  input  wire logic              clk_i,
  input  wire rmp_pkg::mem_req_t req_i,
  output logic [15:0]            rdata_o
);
  import rmp_pkg::*;

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_q;

  // single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[rtl/core/rmp_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module rmp_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rmp_pkg::div_req_t req_i,
  output rmp_pkg::div_rsp_t      rsp_o
);
  import rmp_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [3:0]       rem_q;
  logic [DIV_W-1:0] quot_q;
  logic [4:0]       trial;
  logic             fits;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, quot_q[DIV_W-1]};
  assign fits  = trial >= {1'b0, req_i.den};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q <= CNT_W'(DIV_W);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 1'b1;
        done_q <= (cnt_q == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= '0;
      quot_q <= req_i.num;
    end else if (cnt_q != '0) begin
      rem_q  <= fits ? 4'(trial - {1'b0, req_i.den}) : trial[3:0];
      quot_q <= {quot_q[DIV_W-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule
`default_nettype wire

[rtl/core/rmp_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module rmp_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [2:0]        cfg_index_i,
  input  wire logic [15:0]       cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire rmp_pkg::rmp_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output rmp_pkg::rmp_out_t      out_data_o,
  output rmp_pkg::mem_req_t      mem_o,
  input  wire logic [15:0]       mem_rdata_i,
  output rmp_pkg::div_req_t      div_o,
  input  wire rmp_pkg::div_rsp_t div_i
);
  import rmp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCALE, ST_SIZE, ST_DIV_GO, ST_DIV_WAIT, ST_SCAN, ST_DRAIN, ST_OUT
  } state_e;

  state_e state_q;

  logic [5:0]  mh_q, mw_q;
  logic [3:0]  ph_q, pw_q;
  logic [15:0] scale_q;
  logic [5:0]  mh_e, mw_e;
  logic [3:0]  ph_e, pw_e;

  logic [15:0] coord_q [4];
  logic [12:0] sc_q [4];
  logic [2:0]  cnt_q;
  logic [31:0] prod_q;
  logic [32:0] rnd;
  logic [CH_W-1:0] ch_q;
  logic [13:0] sh_q, sw_q;
  logic [13:0] yend, xend;
  logic [15:0] acc_y_q, acc_x_q;
  logic [2:0]  by_q, bx_q;
  logic [5:0]  bin_q;
  logic [1:0]  sel_q;
  logic [5:0]  hs_q, he_q, ws_q, we_q;
  logic [5:0]  r_q, c_q;
  logic        pend_q, seen_q;
  logic signed [15:0] best_q, best_d, rd_val;
  logic [16:0] bound;
  logic [5:0]  lim;
  logic [5:0]  bound_c;
  logic        last_bin, empty_bin, last_cell;
  logic        in_acc;

  // effective register values
  assign mh_e = (mh_q > 6'(MAP_ROWS)) ? 6'(MAP_ROWS) : mh_q;
  assign mw_e = (mw_q > 6'(MAP_COLS)) ? 6'(MAP_COLS) : mw_q;
  assign ph_e = (ph_q == 4'd0) ? 4'd1 : ((ph_q > 4'(MAX_POOLED)) ? 4'(MAX_POOLED) : ph_q);
  assign pw_e = (pw_q == 4'd0) ? 4'd1 : ((pw_q > 4'(MAX_POOLED)) ? 4'(MAX_POOLED) : pw_q);

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // corner rounding of the registered product
  assign rnd = {1'b0, prod_q} + 33'(1 << 19);

  // roi extents
  assign yend = {1'b0, sc_q[3]} + 14'd1;
  assign xend = {1'b0, sc_q[2]} + 14'd1;

  // divider operand select
  always_comb begin
    div_o.start = (state_q == ST_DIV_GO);
    div_o.den   = sel_q[1] ? pw_e : ph_e;
    case (sel_q)
      2'd0:    div_o.num = acc_y_q;
      2'd1:    div_o.num = acc_y_q + {2'b0, sh_q} + {12'b0, ph_e} - 16'd1;
      2'd2:    div_o.num = acc_x_q;
      default: div_o.num = acc_x_q + {2'b0, sw_q} + {12'b0, pw_e} - 16'd1;
    endcase
  end

  // offset and clamp of a bin bound
  always_comb begin
    bound   = {1'b0, div_i.quot} + (sel_q[1] ? {4'b0, sc_q[0]} : {4'b0, sc_q[1]});
    lim     = sel_q[1] ? mw_e : mh_e;
    bound_c = (bound > {11'b0, lim}) ? lim : bound[5:0];
  end

  // store access
  assign mem_o.we    = in_acc && (in_data_i.req_type == REQ_LOAD);
  assign mem_o.waddr = in_data_i.load_address[ADDR_W-1:0];
  assign mem_o.wdata = in_data_i.load_value;
  assign mem_o.raddr = {ch_q, r_q[ROW_W-1:0], c_q[COL_W-1:0]};

  // running maximum
  assign rd_val = mem_rdata_i;
  always_comb begin
    best_d = best_q;
    if (pend_q && (!seen_q || rd_val > best_q)) begin
      best_d = rd_val;
    end
  end

  assign empty_bin = (hs_q >= he_q) || (ws_q >= we_q);
  assign last_cell = (r_q == he_q - 6'd1) && (c_q == we_q - 6'd1);
  assign last_bin  = ({1'b0, by_q} == ph_e - 4'd1) && ({1'b0, bx_q} == pw_e - 4'd1);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mh_q    <= 6'd32;
      mw_q    <= 6'd32;
      ph_q    <= 4'd7;
      pw_q    <= 4'd7;
      scale_q <= 16'd4096;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MAP_HEIGHT:    mh_q    <= cfg_wdata_i[5:0];
        CFG_MAP_WIDTH:     mw_q    <= cfg_wdata_i[5:0];
        CFG_POOLED_HEIGHT: ph_q    <= cfg_wdata_i[3:0];
        CFG_POOLED_WIDTH:  pw_q    <= cfg_wdata_i[3:0];
        CFG_SPATIAL_SCALE: scale_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      sel_q   <= '0;
      pend_q  <= 1'b0;
      seen_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc && (in_data_i.req_type == REQ_POOL)) begin
            state_q <= ST_SCALE;
            cnt_q   <= '0;
          end
        end
        ST_SCALE: begin
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd4) begin
            state_q <= ST_SIZE;
          end
        end
        ST_SIZE: begin
          sel_q   <= 2'd0;
          state_q <= ST_DIV_GO;
        end
        ST_DIV_GO: state_q <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (div_i.done) begin
            sel_q <= sel_q + 2'd1;
            if (sel_q == 2'd3) begin
              state_q <= ST_SCAN;
              pend_q  <= 1'b0;
              seen_q  <= 1'b0;
            end else begin
              state_q <= ST_DIV_GO;
            end
          end
        end
        ST_SCAN: begin
          if (pend_q) begin
            seen_q <= 1'b1;
          end
          if (empty_bin) begin
            state_q <= ST_OUT;
          end else begin
            pend_q <= 1'b1;
            if (last_cell) begin
              state_q <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          pend_q  <= 1'b0;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready_i) begin
            if (last_bin) begin
              state_q <= ST_IDLE;
            end else begin
              state_q <= ST_DIV_GO;
              sel_q   <= ({1'b0, bx_q} == pw_e - 4'd1) ? 2'd0 : 2'd2;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        coord_q[0] <= in_data_i.roi_x1;
        coord_q[1] <= in_data_i.roi_y1;
        coord_q[2] <= in_data_i.roi_x2;
        coord_q[3] <= in_data_i.roi_y2;
        ch_q       <= in_data_i.channel[CH_W-1:0];
      end
      ST_SCALE: begin
        prod_q <= coord_q[cnt_q[1:0]] * scale_q;
        if (cnt_q != 3'd0) begin
          sc_q[2'(cnt_q - 3'd1)] <= rnd[32:20];
        end
      end
      ST_SIZE: begin
        sh_q    <= (yend > {1'b0, sc_q[1]}) ? yend - {1'b0, sc_q[1]} : 14'd1;
        sw_q    <= (xend > {1'b0, sc_q[0]}) ? xend - {1'b0, sc_q[0]} : 14'd1;
        acc_y_q <= '0;
        acc_x_q <= '0;
        by_q    <= '0;
        bx_q    <= '0;
        bin_q   <= '0;
      end
      ST_DIV_WAIT: begin
        if (div_i.done) begin
          case (sel_q)
            2'd0:    hs_q <= bound_c;
            2'd1:    he_q <= bound_c;
            2'd2:    ws_q <= bound_c;
            default: we_q <= bound_c;
          endcase
          r_q    <= hs_q;
          c_q    <= (sel_q == 2'd3) ? ws_q : c_q;
          best_q <= '0;
        end
      end
      ST_SCAN: begin
        best_q <= best_d;
        if (!empty_bin) begin
          if (c_q == we_q - 6'd1) begin
            c_q <= ws_q;
            r_q <= r_q + 6'd1;
          end else begin
            c_q <= c_q + 6'd1;
          end
        end
      end
      ST_DRAIN: best_q <= best_d;
      ST_OUT: begin
        if (out_ready_i) begin
          bin_q <= bin_q + 6'd1;
          if ({1'b0, bx_q} == pw_e - 4'd1) begin
            bx_q    <= '0;
            acc_x_q <= '0;
            by_q    <= by_q + 3'd1;
            acc_y_q <= acc_y_q + {2'b0, sh_q};
          end else begin
            bx_q    <= bx_q + 3'd1;
            acc_x_q <= acc_x_q + {2'b0, sw_q};
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o             = (state_q == ST_OUT);
  assign out_data_o.pooled_value = best_q;
  assign out_data_o.bin_index    = bin_q;
  assign out_data_o.last         = last_bin;

endmodule
`default_nettype wire
